// File: rtl/btlt_pkg.sv
package btlt_pkg;

  // Default table depth
  localparam int LABEL_ENTRIES_DEF = 128;

  // Action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_SEED   = 2'd1;
  localparam logic [1:0] ACT_SCAN   = 2'd2;
  localparam logic [1:0] ACT_LOOKUP = 2'd3;

  // Stored label kinds
  localparam logic [1:0] KIND_GEN   = 2'd0;
  localparam logic [1:0] KIND_NMI   = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;
  localparam logic [1:0] KIND_IRQ   = 2'd3;

  // Seed vector codes
  localparam logic [1:0] VEC_NMI   = 2'd0;
  localparam logic [1:0] VEC_RESET = 2'd1;

  // Absolute jump opcodes
  localparam logic [7:0] OP_JSR = 8'h20;
  localparam logic [7:0] OP_JMP = 8'h4C;

  // Addressing mode holding a relative target
  localparam logic [3:0] MODE_REL = 4'd13;

  // Decode entries: {mode, length}
  localparam logic [5:0] T_IMP = 6'd1;
  localparam logic [5:0] T_ACC = 6'd5;
  localparam logic [5:0] T_IMM = 6'd10;
  localparam logic [5:0] T_ZP  = 6'd14;
  localparam logic [5:0] T_ZPX = 6'd18;
  localparam logic [5:0] T_ZPY = 6'd22;
  localparam logic [5:0] T_ABS = 6'd27;
  localparam logic [5:0] T_ABX = 6'd31;
  localparam logic [5:0] T_ABY = 6'd35;
  localparam logic [5:0] T_IND = 6'd39;
  localparam logic [5:0] T_INX = 6'd42;
  localparam logic [5:0] T_INY = 6'd46;
  localparam logic [5:0] T_ZPI = 6'd50;
  localparam logic [5:0] T_REL = 6'd54;
  localparam logic [5:0] T_BB  = 6'd55;

  localparam logic [5:0] DECODE_TAB [256] = '{
    T_IMP,T_INX,T_IMP,T_IMP,T_ZP,T_ZP,T_ZP,T_ZP,T_IMP,T_IMM,T_ACC,T_IMP,T_ABS,T_ABS,T_ABS,T_BB,
    T_REL,T_INY,T_ZPI,T_IMP,T_ZP,T_ZPX,T_ZPX,T_ZP,T_IMP,T_ABY,T_ACC,T_IMP,T_ABS,T_ABX,T_ABX,T_BB,
    T_ABS,T_INX,T_IMP,T_IMP,T_ZP,T_ZP,T_ZP,T_ZP,T_IMP,T_IMM,T_ACC,T_IMP,T_ABS,T_ABS,T_ABS,T_BB,
    T_REL,T_INY,T_ZPI,T_IMP,T_ZPX,T_ZPX,T_ZPX,T_ZP,T_IMP,T_ABY,T_ACC,T_IMP,T_ABX,T_ABX,T_ABX,T_BB,
    T_IMP,T_INX,T_IMP,T_IMP,T_IMP,T_ZP,T_ZP,T_ZP,T_IMP,T_IMM,T_ACC,T_IMP,T_ABS,T_ABS,T_ABS,T_BB,
    T_REL,T_INY,T_ZPI,T_IMP,T_IMP,T_ZPX,T_ZPX,T_ZP,T_IMP,T_ABY,T_IMP,T_IMP,T_IMP,T_ABX,T_ABX,T_BB,
    T_IMP,T_INX,T_IMP,T_IMP,T_ZP,T_ZP,T_ZP,T_ZP,T_IMP,T_IMM,T_ACC,T_IMP,T_IND,T_ABS,T_ABS,T_BB,
    T_REL,T_INY,T_ZPI,T_IMP,T_ZPX,T_ZPX,T_ZPX,T_ZP,T_IMP,T_ABY,T_IMP,T_IMP,T_ABX,T_ABX,T_ABX,T_BB,
    T_REL,T_INX,T_IMP,T_IMP,T_ZP,T_ZP,T_ZP,T_ZP,T_IMP,T_IMM,T_IMP,T_IMP,T_ABS,T_ABS,T_ABS,T_BB,
    T_REL,T_INY,T_ZPI,T_IMP,T_ZPX,T_ZPX,T_ZPY,T_ZP,T_IMP,T_ABY,T_IMP,T_IMP,T_ABS,T_ABX,T_ABX,T_BB,
    T_IMM,T_INX,T_IMM,T_IMP,T_ZP,T_ZP,T_ZP,T_ZP,T_IMP,T_IMM,T_IMP,T_IMP,T_ABS,T_ABS,T_ABS,T_BB,
    T_REL,T_INY,T_ZPI,T_IMP,T_ZPX,T_ZPX,T_ZPY,T_ZP,T_IMP,T_ABY,T_IMP,T_IMP,T_ABX,T_ABX,T_ABY,T_BB,
    T_IMM,T_INX,T_IMP,T_IMP,T_ZP,T_ZP,T_ZP,T_ZP,T_IMP,T_IMM,T_IMP,T_IMP,T_ABS,T_ABS,T_ABS,T_BB,
    T_REL,T_INY,T_ZPI,T_IMP,T_IMP,T_ZPX,T_ZPX,T_ZP,T_IMP,T_ABY,T_IMP,T_IMP,T_IMP,T_ABX,T_ABX,T_BB,
    T_IMM,T_INX,T_IMP,T_IMP,T_ZP,T_ZP,T_ZP,T_ZP,T_IMP,T_IMM,T_IMP,T_IMP,T_ABS,T_ABS,T_ABS,T_BB,
    T_REL,T_INY,T_ZPI,T_IMP,T_IMP,T_ZPX,T_ZPX,T_ZP,T_IMP,T_ABY,T_IMP,T_IMP,T_IMP,T_ABX,T_ABX,T_BB
  };

  // Opcode decode: {mode[3:0], length[1:0]}
  function automatic logic [5:0] decode_op(input logic [7:0] op);
    return DECODE_TAB[op];
  endfunction

  // One table entry
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
  } label_t;

endpackage

// File: rtl/branch_target_label_table_core.sv
// Channel | Signals                                      | Transaction when
// --------+----------------------------------------------+---------------------------
// in      | in_valid, in_ready, action .. vector_kind    | in_valid & in_ready
// out     | out_valid, out_ready, hit .. table_full      | out_valid & out_ready
//
// Clear, seed and non-branch scan items need no search; a scan with a target or a lookup
// searches the live entries (at most LABEL_ENTRIES) by a one-read-per-cycle walk of the
// label memory, and a scan that misses inserts its target when there is room.
// One item is in work at a time; a new one is taken while a result waits at the output.
// Reset (rst, synchronous) empties the table at once; memory contents are not cleared.
// A stalled output holds its result; the block waits in its final state until the
// output register is free.
module branch_target_label_table_core #(
  parameter int LABEL_ENTRIES = btlt_pkg::LABEL_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] address,
  input  logic [7:0]  opcode,
  input  logic [7:0]  operand_low,
  input  logic [7:0]  operand_high,
  input  logic [1:0]  vector_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [6:0]  entry_index,
  output logic [1:0]  entry_kind,
  output logic [15:0] next_address,
  output logic [1:0]  instr_length,
  output logic [3:0]  addr_mode,
  output logic        target_valid,
  output logic [15:0] target_address,
  output logic        inserted,
  output logic        table_full
);

  localparam int IDX_W = $clog2(LABEL_ENTRIES);
  localparam int CNT_W = $clog2(LABEL_ENTRIES + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_INSERT = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state;

  // Label memory, synchronous read
  btlt_pkg::label_t mem [LABEL_ENTRIES];
  btlt_pkg::label_t rd_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] iss_idx;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;

  // Working item
  logic [1:0]  act;
  logic [15:0] key;
  logic        w_hit;
  logic [6:0]  w_idx;
  logic [1:0]  w_kind;
  logic [15:0] w_next;
  logic [1:0]  w_len;
  logic [3:0]  w_mode;
  logic        w_tv;
  logic        w_ins;
  logic        w_full;

  // Decode of the incoming instruction
  logic [5:0]  dec;
  logic [1:0]  dec_len;
  logic [3:0]  dec_mode;
  logic        dec_tv;
  logic [15:0] dec_tgt;
  logic [1:0]  seed_kind;
  logic        room;
  logic        in_fire;
  logic        out_free;

  assign dec      = btlt_pkg::decode_op(opcode);
  assign dec_len  = dec[1:0];
  assign dec_mode = dec[5:2];
  assign room     = count < CNT_W'(LABEL_ENTRIES);
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Target address: relative branch, BBR/BBS, or absolute JSR/JMP
  always_comb begin
    dec_tv  = 1'b0;
    dec_tgt = 16'd0;
    if (dec_mode == btlt_pkg::MODE_REL) begin
      dec_tv = 1'b1;
      if (dec_len == 2'd3) begin
        dec_tgt = address + 16'd3 + {{8{operand_high[7]}}, operand_high};
      end else begin
        dec_tgt = address + 16'd2 + {{8{operand_low[7]}}, operand_low};
      end
    end else if (opcode == btlt_pkg::OP_JSR || opcode == btlt_pkg::OP_JMP) begin
      dec_tv  = 1'b1;
      dec_tgt = {operand_high, operand_low};
    end
  end

  always_comb begin
    case (vector_kind)
      btlt_pkg::VEC_NMI:   seed_kind = btlt_pkg::KIND_NMI;
      btlt_pkg::VEC_RESET: seed_kind = btlt_pkg::KIND_RESET;
      default:             seed_kind = btlt_pkg::KIND_IRQ;
    endcase
  end

  // Search read port
  assign rd_en   = (state == ST_SEARCH) && !(pend && rd_data.addr == key) && (iss_idx < count);
  assign rd_addr = iss_idx[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (state == ST_INSERT) begin
      mem[count[IDX_W-1:0]] <= '{kind: w_kind, addr: key};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Result register: load when done, drop when taken
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (action)
              btlt_pkg::ACT_CLEAR: begin
                count <= '0;
                state <= ST_DONE;
              end
              btlt_pkg::ACT_SEED: begin
                state <= room ? ST_INSERT : ST_DONE;
              end
              btlt_pkg::ACT_SCAN: begin
                state <= dec_tv ? ST_SEARCH : ST_DONE;
              end
              default: begin
                state <= ST_SEARCH;
              end
            endcase
            iss_idx <= '0;
            pend    <= 1'b0;
          end
        end
        ST_SEARCH: begin
          if (pend && rd_data.addr == key) begin
            pend  <= 1'b0;
            state <= ST_DONE;
          end else if (iss_idx < count) begin
            pend     <= 1'b1;
            pend_idx <= iss_idx[IDX_W-1:0];
            iss_idx  <= iss_idx + 1'b1;
          end else begin
            pend <= 1'b0;
            if (act == btlt_pkg::ACT_LOOKUP || !room) begin
              state <= ST_DONE;
            end else begin
              state <= ST_INSERT;
            end
          end
        end
        ST_INSERT: begin
          count <= count + 1'b1;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Working result fields
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          act    <= action;
          w_hit  <= 1'b0;
          w_idx  <= '0;
          w_ins  <= 1'b0;
          // A seed keeps its vector kind only when it finds room
          w_kind <= (action == btlt_pkg::ACT_SEED && room) ? seed_kind : btlt_pkg::KIND_GEN;
          w_full <= (action == btlt_pkg::ACT_SEED) && !room;
          if (action == btlt_pkg::ACT_SCAN) begin
            w_next <= address + {14'd0, dec_len};
            w_len  <= dec_len;
            w_mode <= dec_mode;
            w_tv   <= dec_tv;
            key    <= dec_tgt;
          end else begin
            w_next <= '0;
            w_len  <= '0;
            w_mode <= '0;
            w_tv   <= 1'b0;
            key    <= address;
          end
        end
      end
      ST_SEARCH: begin
        if (pend && rd_data.addr == key) begin
          w_hit  <= 1'b1;
          w_idx  <= 7'(pend_idx);
          w_kind <= rd_data.kind;
        end else if (!(iss_idx < count) && act == btlt_pkg::ACT_SCAN && !room) begin
          w_full <= 1'b1;
        end
      end
      ST_INSERT: begin
        w_ins <= 1'b1;
        w_idx <= 7'(count);
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      hit            <= w_hit;
      entry_index    <= w_idx;
      entry_kind     <= w_kind;
      next_address   <= w_next;
      instr_length   <= w_len;
      addr_mode      <= w_mode;
      target_valid   <= w_tv;
      target_address <= w_tv ? key : 16'd0;
      inserted       <= w_ins;
      table_full     <= w_full;
    end
  end

endmodule

// File: rtl/btlt_checker.sv
module btlt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [6:0]  entry_index,
  input logic [1:0]  entry_kind,
  input logic [15:0] target_address,
  input logic        target_valid,
  input logic        inserted,
  input logic        table_full
);

  // A stalled result holds its fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry_index) && $stable(hit)
      && $stable(target_address))
    else $error("result changed while stalled");

  // At most one outcome per result
  a_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({hit, inserted, table_full}) <= 1)
    else $error("conflicting hit/inserted/table_full");

  // No entry fields unless an entry was found or written
  a_no_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit && !inserted |-> entry_index == 7'd0 && entry_kind == 2'd0)
    else $error("entry fields set without an entry");

  // Scan inserts are generated labels, seed inserts are vector labels
  a_ins_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && inserted |-> (target_valid == (entry_kind == 2'd0)))
    else $error("inserted kind does not match action");

  // No target address without a target
  a_tgt_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !target_valid |-> target_address == 16'd0)
    else $error("target address without target");

endmodule

bind branch_target_label_table_core btlt_checker u_btlt_checker (.*);
